### hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Both expect clk_i and rst_ni in scope.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CRPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// boolean condition must never be true
`define CRPD_ASSERT_NEVER(lbl, cond) \
  `CRPD_ASSERT(lbl, !(cond))

`endif

### hw/rtl/crpd_pkg.sv
// -----------------------------------------------------------------------------
// crpd_pkg
// Types, constants and helpers shared by the color region pixel detector.
// -----------------------------------------------------------------------------
package crpd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CNT_W     = 21;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int PCT_W     = 7;
  localparam int NUM_PARTS = 3;

  localparam int GREEN_MIN   = 50;
  localparam int YELLOW_MIN  = 150;
  localparam int YELLOW_GAP  = 50;
  localparam int DARK_PCT    = 25;
  localparam int FRONT_PCT   = 1;
  localparam int YEL_SIDE_PCT = 1;
  localparam int YEL_CTR_PCT = 4;
  localparam int PCT_SCALE   = 100;

  localparam int THIRDS     = 3;
  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 1;
  // floor(w/3) == (w * RECIP3) >> RECIP3_SH for w < 8192
  localparam int RECIP3     = 2731;
  localparam int RECIP3_SH  = 13;

  localparam int DEF_FRAME_WIDTH  = 64;
  localparam int DEF_FRAME_HEIGHT = 64;
  localparam int DEF_DARK_LEVEL   = 50;
  localparam int DEF_SIDE_PCT     = 20;
  localparam int DEF_FRONT_PCT    = 30;
  localparam int DEF_CENTER_PCT   = 5;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH      = 3'd0,
    CFG_FRAME_HEIGHT     = 3'd1,
    CFG_DARK_LEVEL       = 3'd2,
    CFG_GREEN_SIDE_PCT   = 3'd3,
    CFG_GREEN_FRONT_PCT  = 3'd4,
    CFG_GREEN_CENTER_PCT = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PART_LEFT   = 2'd0,
    PART_CENTER = 2'd1,
    PART_RIGHT  = 2'd2
  } part_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_last;
  } pixel_t;

  typedef struct packed {
    logic             green_close;
    logic             green_in_front;
    logic             yellow_line;
    logic [CNT_W-1:0] left_green_count;
    logic [CNT_W-1:0] center_green_count;
    logic [CNT_W-1:0] right_green_count;
  } result_t;

  typedef struct packed {
    part_e part;
    logic  green;
    logic  yellow;
    logic  dark;
    logic  frame_last;
  } item_t;

  // width of the percent products: count*100 and pct*area
  function automatic int thr_width(input int max_w, input int max_h);
    int aw;
    aw = $clog2(max_w + 1) + $clog2(max_h + 1);
    return (aw + PCT_W > CNT_W + PCT_W) ? aw + PCT_W : CNT_W + PCT_W;
  endfunction

endpackage

### hw/rtl/crpd_front.sv
// -----------------------------------------------------------------------------
// crpd_front
// Config registers, area thresholds, column counter, region select and pixel classing.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module crpd_front import crpd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int TW         = thr_width(MAX_WIDTH_DEF, MAX_HEIGHT_DEF)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  pixel_t               in_pixel_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 q_wr_valid_o,
  output item_t                q_item_o,
  output logic [TW-1:0]        thr_side_o,
  output logic [TW-1:0]        thr_front_o,
  output logic [TW-1:0]        thr_center_o,
  output logic [TW-1:0]        thr_dark_o,
  output logic [TW-1:0]        thr_one_o,
  output logic [TW-1:0]        thr_four_o
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int AW  = WW + HW;
  localparam int CW  = (WW > CFG_W) ? WW : CFG_W;
  localparam int CH  = (HW > CFG_W) ? HW : CFG_W;
  localparam int PW  = WW + RECIP3_SH;

  localparam int W_RST   = (DEF_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_FRAME_WIDTH;
  localparam int H_RST   = (DEF_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEF_FRAME_HEIGHT;
  localparam int W3_RST  = W_RST / THIRDS;
  localparam int W23_RST = (2 * W_RST) / THIRDS;

  logic [WW-1:0]    w_q, w3_q, w23_q;
  logic [HW-1:0]    h_q;
  logic [7:0]       dark_q;
  logic [PCT_W-1:0] side_q, front_q, center_q;
  logic [CLW-1:0]   col_q, col_d;

  logic [AW-1:0] area_q;
  logic [TW-1:0] thr_side_q, thr_front_q, thr_center_q;
  logic [TW-1:0] thr_dark_q, thr_one_q, thr_four_q;

  logic [CW-1:0] wext, wclamp;
  logic [CH-1:0] hext, hclamp;
  logic [WW-1:0] wc, w3c, w3x3, wrem, w23c;
  logic [HW-1:0] hc;
  logic [PW-1:0] w3_prod;

  logic          acc;
  logic [CLW:0]  col_inc;
  logic [WW-1:0] col_ext;
  logic signed [9:0] diff_gb, diff_gr, diff_rb, half_g;
  logic [7:0]    r, g, b;
  logic          is_green, is_yellow, is_dark;
  part_e         part;

  // width clamp and thirds split, resolved at write time
  always_comb begin
    wext    = CW'(cfg_wdata_i);
    wclamp  = (wext < CW'(MIN_WIDTH)) ? CW'(MIN_WIDTH) :
              (wext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : wext;
    wc      = wclamp[WW-1:0];
    w3_prod = PW'(wc) * PW'(RECIP3);
    w3c     = w3_prod[RECIP3_SH +: WW];
    w3x3    = WW'({w3c, 1'b0}) + w3c;
    wrem    = wc - w3x3;
    w23c    = WW'({w3c, 1'b0}) + WW'(wrem[1:0] == 2'd2);
    hext    = CH'(cfg_wdata_i);
    hclamp  = (hext < CH'(MIN_HEIGHT)) ? CH'(MIN_HEIGHT) :
              (hext > CH'(MAX_HEIGHT)) ? CH'(MAX_HEIGHT) : hext;
    hc      = hclamp[HW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= WW'(W_RST);
      w3_q     <= WW'(W3_RST);
      w23_q    <= WW'(W23_RST);
      h_q      <= HW'(H_RST);
      dark_q   <= 8'(DEF_DARK_LEVEL);
      side_q   <= PCT_W'(DEF_SIDE_PCT);
      front_q  <= PCT_W'(DEF_FRONT_PCT);
      center_q <= PCT_W'(DEF_CENTER_PCT);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH: begin
          w_q   <= wc;
          w3_q  <= w3c;
          w23_q <= w23c;
        end
        CFG_FRAME_HEIGHT:     h_q      <= hc;
        CFG_DARK_LEVEL:       dark_q   <= cfg_wdata_i[7:0];
        CFG_GREEN_SIDE_PCT:   side_q   <= cfg_wdata_i[PCT_W-1:0];
        CFG_GREEN_FRONT_PCT:  front_q  <= cfg_wdata_i[PCT_W-1:0];
        CFG_GREEN_CENTER_PCT: center_q <= cfg_wdata_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // registered region area, then percent thresholds registered from area_q
  always_ff @(posedge clk_i) begin
    area_q       <= AW'(w3_q) * AW'(h_q);
    thr_side_q   <= TW'(side_q) * TW'(area_q);
    thr_front_q  <= TW'(front_q) * TW'(area_q);
    thr_center_q <= TW'(center_q) * TW'(area_q);
    thr_dark_q   <= TW'(area_q) * TW'(DARK_PCT);
    thr_one_q    <= TW'(area_q) * TW'(FRONT_PCT);
    thr_four_q   <= TW'(area_q) * TW'(YEL_CTR_PCT);
  end

  assign thr_side_o   = thr_side_q;
  assign thr_front_o  = thr_front_q;
  assign thr_center_o = thr_center_q;
  assign thr_dark_o   = thr_dark_q;
  assign thr_one_o    = thr_one_q;
  assign thr_four_o   = thr_four_q;

  assign acc        = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    r       = in_pixel_i.red;
    g       = in_pixel_i.green;
    b       = in_pixel_i.blue;
    diff_gb = $signed({2'b00, g}) - $signed({2'b00, b});
    diff_gr = $signed({2'b00, g}) - $signed({2'b00, r});
    diff_rb = $signed({2'b00, r}) - $signed({2'b00, b});
    half_g  = $signed({3'b000, g[7:1]});
    is_green  = (g >= 8'(GREEN_MIN)) && (diff_gb >= half_g) && (diff_gr >= half_g);
    is_yellow = (r >= 8'(YELLOW_MIN)) && (g >= 8'(YELLOW_MIN)) &&
                (diff_rb >= $signed(10'(YELLOW_GAP))) &&
                (diff_gb >= $signed(10'(YELLOW_GAP)));
    is_dark   = (r < dark_q) && (g < dark_q) && (b < dark_q);

    col_ext = WW'(col_q);
    if (col_ext < w3_q) begin
      part = PART_LEFT;
    end else if (col_ext < w23_q) begin
      part = PART_CENTER;
    end else begin
      part = PART_RIGHT;
    end

    col_inc = {1'b0, col_q} + (CLW+1)'(1);
    if (in_pixel_i.frame_last || (col_inc >= (CLW+1)'(w_q))) begin
      col_d = '0;
    end else begin
      col_d = col_inc[CLW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
    end
  end

  assign q_wr_valid_o         = acc;
  assign q_item_o.part        = part;
  assign q_item_o.green       = is_green;
  assign q_item_o.yellow      = is_yellow;
  assign q_item_o.dark        = is_dark;
  assign q_item_o.frame_last  = in_pixel_i.frame_last;

  `CRPD_ASSERT(a_col_clear_on_last, (acc && in_pixel_i.frame_last) |=> (col_q == '0))

endmodule

### hw/rtl/crpd_queue.sv
// -----------------------------------------------------------------------------
// crpd_queue
// Small FIFO of classified pixels between front and back.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module crpd_queue import crpd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  input  item_t wr_item_i,
  output logic  full_o,
  output logic  rd_valid_o,
  output item_t rd_item_o,
  input  logic  rd_en_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             push, pop;

  assign full_o     = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && !full_o;
  assign pop        = rd_en_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  `CRPD_ASSERT_NEVER(a_cnt_bound, cnt_q > (PTR_W+1)'(QUEUE_DEPTH))
  `CRPD_ASSERT(a_no_pop_empty, rd_en_i |-> rd_valid_o)

endmodule

### hw/rtl/crpd_back.sv
// -----------------------------------------------------------------------------
// crpd_back
// Per-region class counters, frame-end percent tests and result register.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module crpd_back import crpd_pkg::*; #(
  parameter int TW = thr_width(MAX_WIDTH_DEF, MAX_HEIGHT_DEF)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  item_t         q_item_i,
  output logic          q_rd_o,
  input  logic [TW-1:0] thr_side_i,
  input  logic [TW-1:0] thr_front_i,
  input  logic [TW-1:0] thr_center_i,
  input  logic [TW-1:0] thr_dark_i,
  input  logic [TW-1:0] thr_one_i,
  input  logic [TW-1:0] thr_four_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output result_t       out_result_o
);

  logic [CNT_W-1:0] grn_q [NUM_PARTS];
  logic [CNT_W-1:0] yel_q [NUM_PARTS];
  logic [CNT_W-1:0] drk_q [NUM_PARTS];
  logic [CNT_W-1:0] grn_b [NUM_PARTS];
  logic [CNT_W-1:0] yel_b [NUM_PARTS];
  logic [CNT_W-1:0] drk_b [NUM_PARTS];

  logic [CNT_W-1:0] s1_grn_q [NUM_PARTS];
  logic [CNT_W-1:0] s1_yel_q [NUM_PARTS];
  logic [CNT_W-1:0] s1_drk_q [NUM_PARTS];
  logic             s1_v_q;

  logic [CNT_W-1:0] s2_grn_q [NUM_PARTS];
  logic [TW-1:0]    p_grn_q [NUM_PARTS];
  logic [TW-1:0]    p_yel_q [NUM_PARTS];
  logic [TW-1:0]    p_drk_q [NUM_PARTS];
  logic             s2_gtl_q, s2_gtr_q, s2_v_q;

  logic    out_v_q;
  result_t res_q, res_d;
  logic    en, pop, last, sel, any_dark;

  assign en     = !out_v_q || !out_stall_i;
  assign pop    = q_valid_i && en;
  assign last   = q_item_i.frame_last;
  assign q_rd_o = pop;

  always_comb begin
    for (int i = 0; i < NUM_PARTS; i++) begin
      sel      = (q_item_i.part == part_e'(i));
      grn_b[i] = grn_q[i] + CNT_W'(sel && q_item_i.green && (grn_q[i] != CNT_MAX));
      yel_b[i] = yel_q[i] + CNT_W'(sel && q_item_i.yellow && (yel_q[i] != CNT_MAX));
      drk_b[i] = drk_q[i] + CNT_W'(sel && q_item_i.dark && (drk_q[i] != CNT_MAX));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        grn_q[i] <= '0;
        yel_q[i] <= '0;
        drk_q[i] <= '0;
      end
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop) begin
        for (int i = 0; i < NUM_PARTS; i++) begin
          grn_q[i] <= last ? '0 : grn_b[i];
          yel_q[i] <= last ? '0 : yel_b[i];
          drk_q[i] <= last ? '0 : drk_b[i];
        end
      end
      if (en) begin
        s1_v_q  <= pop && last;
        s2_v_q  <= s1_v_q;
        out_v_q <= s2_v_q;
      end
    end
  end

  always_comb begin
    any_dark = 1'b0;
    for (int i = 0; i < NUM_PARTS; i++) begin
      any_dark = any_dark || (p_drk_q[i] > thr_dark_i);
    end
    res_d.green_close    = (p_grn_q[PART_LEFT] > thr_side_i) ||
                           (p_grn_q[PART_CENTER] > thr_front_i) ||
                           (p_grn_q[PART_RIGHT] > thr_side_i);
    res_d.green_in_front = ((p_grn_q[PART_CENTER] > thr_center_i) && s2_gtl_q && s2_gtr_q) ||
                           ((p_grn_q[PART_CENTER] > thr_one_i) && any_dark);
    res_d.yellow_line    = (p_yel_q[PART_LEFT] > thr_one_i) &&
                           (p_yel_q[PART_CENTER] > thr_four_i) &&
                           (p_yel_q[PART_RIGHT] > thr_one_i);
    res_d.left_green_count   = s2_grn_q[PART_LEFT];
    res_d.center_green_count = s2_grn_q[PART_CENTER];
    res_d.right_green_count  = s2_grn_q[PART_RIGHT];
  end

  always_ff @(posedge clk_i) begin
    if (pop && last) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        s1_grn_q[i] <= grn_b[i];
        s1_yel_q[i] <= yel_b[i];
        s1_drk_q[i] <= drk_b[i];
      end
    end
    if (en) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        s2_grn_q[i] <= s1_grn_q[i];
        p_grn_q[i]  <= TW'(s1_grn_q[i]) * TW'(PCT_SCALE);
        p_yel_q[i]  <= TW'(s1_yel_q[i]) * TW'(PCT_SCALE);
        p_drk_q[i]  <= TW'(s1_drk_q[i]) * TW'(PCT_SCALE);
      end
      s2_gtl_q <= s1_grn_q[PART_CENTER] > s1_grn_q[PART_LEFT];
      s2_gtr_q <= s1_grn_q[PART_CENTER] > s1_grn_q[PART_RIGHT];
      res_q    <= res_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_result_o = res_q;

  `CRPD_ASSERT(a_clear_on_last, (pop && last) |=> ((grn_q[0] == '0) && (grn_q[1] == '0) && (grn_q[2] == '0)))
  `CRPD_ASSERT(a_stage_order, (en && s1_v_q) |=> s2_v_q)

endmodule

### hw/rtl/color_region_pixel_detector_core.sv
// -----------------------------------------------------------------------------
// color_region_pixel_detector_core
// Counts green, yellow and dark pixels per third of the frame and flags
// green objects and yellow lines at frame end.
// -----------------------------------------------------------------------------
// Takes one pixel per clock in raster order; in_stall_o rises only when the
// four-entry pixel queue is full, which happens only while the result side is
// stalled. A result beat follows each accepted frame_last pixel once it has
// passed the queue, the count snapshot, the percent products and the result
// register. Width and height writes feed a registered area/threshold chain:
// the area register, then the threshold registers.
module color_region_pixel_detector_core import crpd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pixel_t               in_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output result_t              out_result_o
);

  localparam int TW = thr_width(MAX_WIDTH, MAX_HEIGHT);

  logic          q_full, q_wr_valid, q_rd_valid, q_rd;
  item_t         q_wr_item, q_rd_item;
  logic [TW-1:0] thr_side, thr_front, thr_center, thr_dark, thr_one, thr_four;

  crpd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .TW         (TW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_pixel_i   (in_pixel_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .q_wr_valid_o (q_wr_valid),
    .q_item_o     (q_wr_item),
    .thr_side_o   (thr_side),
    .thr_front_o  (thr_front),
    .thr_center_o (thr_center),
    .thr_dark_o   (thr_dark),
    .thr_one_o    (thr_one),
    .thr_four_o   (thr_four)
  );

  crpd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (q_wr_valid),
    .wr_item_i  (q_wr_item),
    .full_o     (q_full),
    .rd_valid_o (q_rd_valid),
    .rd_item_o  (q_rd_item),
    .rd_en_i    (q_rd)
  );

  crpd_back #(
    .TW (TW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_rd_valid),
    .q_item_i     (q_rd_item),
    .q_rd_o       (q_rd),
    .thr_side_i   (thr_side),
    .thr_front_i  (thr_front),
    .thr_center_i (thr_center),
    .thr_dark_i   (thr_dark),
    .thr_one_i    (thr_one),
    .thr_four_i   (thr_four),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o)
  );

endmodule

### bench/tb_color_region_pixel_detector_core.sv
// -----------------------------------------------------------------------------
// tb_color_region_pixel_detector_core
// Self-checking bench for the color region pixel detector core.
// -----------------------------------------------------------------------------
// Streams raster pixels through the core under a series of register settings.
// It starts with short directed frames and then runs random frames. Every
// accepted pixel goes through a local model of the per-third class counters.
// Each frame_last beat queues the expected flags and green counts, and every
// result beat is compared with the oldest of them. Both sides idle at random.
// -----------------------------------------------------------------------------
module tb_color_region_pixel_detector_core;
  import crpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;
  typedef enum int {KIND_GREEN, KIND_YELLOW, KIND_DARK, KIND_NOISE} pixel_kind_e;

  localparam int WIDTH_CAP       = MAX_WIDTH_DEF;
  localparam int HEIGHT_CAP      = MAX_HEIGHT_DEF;
  localparam int G_FLOOR         = 50;
  localparam int Y_FLOOR         = 150;
  localparam int Y_BLUE_GAP      = 50;
  localparam int DARK_SHARE      = 25;
  localparam int AHEAD_SHARE     = 1;
  localparam int YSIDE_SHARE     = 1;
  localparam int YCTR_SHARE      = 4;
  localparam int DRAIN_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 3;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 10;
  localparam int PHASE_ITEMS     = 200;
  localparam int SHARES [4]      = '{0, 15, 50, 90};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  pixel_t               in_pixel_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  result_t              out_result_o;

  color_region_pixel_detector_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_pixel_i,
    .out_valid_o,
    .out_stall_i,
    .out_result_o
  );

  always #5 clk_i = ~clk_i;

  // register shadows
  logic [10:0] cfg_width  = DEF_FRAME_WIDTH;
  logic [10:0] cfg_height = DEF_FRAME_HEIGHT;
  logic [7:0]  cfg_dark   = DEF_DARK_LEVEL;
  logic [6:0]  cfg_side   = DEF_SIDE_PCT;
  logic [6:0]  cfg_front  = DEF_FRONT_PCT;
  logic [6:0]  cfg_center = DEF_CENTER_PCT;

  // model state
  int unsigned    col_pos = 0;
  logic [20:0]    green_tally [3] = '{default: '0};
  logic [20:0]    yellow_tally [3] = '{default: '0};
  logic [20:0]    dark_tally [3] = '{default: '0};

  pixel_t  pixel_q [$];
  result_t frame_reports_q [$];
  int      fail_cnt = 0;
  int      in_gap = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;
  int      calm_timer = 0;
  logic    calm = 1'b0;
  int      plan_col = 0;

  function automatic int unsigned eff_width(input logic [10:0] w);
    if (w < 3) return 3;
    if (w > WIDTH_CAP) return WIDTH_CAP;
    return w;
  endfunction

  function automatic logic [20:0] sat_inc(input logic [20:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic bit exceeds(input logic [20:0] cnt, input int unsigned pct,
                                 input u64_t area);
    return u64_t'(cnt) * 100 > u64_t'(pct) * area;
  endfunction

  task automatic tally_pixel(input pixel_t px);
    int unsigned w, h, third;
    int          r, g, b;
    part_e       part;
    u64_t        area;
    result_t     rep;
    bit          dark_any;
    w = eff_width(cfg_width);
    h = cfg_height;
    if (h < 1) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    third = w / 3;
    if (col_pos < third) part = PART_LEFT;
    else if (col_pos < (2 * w) / 3) part = PART_CENTER;
    else part = PART_RIGHT;
    r = px.red;
    g = px.green;
    b = px.blue;
    if (g >= G_FLOOR && g - b >= g / 2 && g - r >= g / 2)
      green_tally[int'(part)] = sat_inc(green_tally[int'(part)]);
    if (r >= Y_FLOOR && g >= Y_FLOOR && r - b >= Y_BLUE_GAP && g - b >= Y_BLUE_GAP)
      yellow_tally[int'(part)] = sat_inc(yellow_tally[int'(part)]);
    if (r < cfg_dark && g < cfg_dark && b < cfg_dark)
      dark_tally[int'(part)] = sat_inc(dark_tally[int'(part)]);
    col_pos++;
    if (col_pos >= w) col_pos = 0;
    if (px.frame_last) begin
      area = u64_t'(third) * u64_t'(h);
      dark_any = exceeds(dark_tally[0], DARK_SHARE, area) ||
                 exceeds(dark_tally[1], DARK_SHARE, area) ||
                 exceeds(dark_tally[2], DARK_SHARE, area);
      rep.green_close = exceeds(green_tally[0], cfg_side, area) ||
                        exceeds(green_tally[1], cfg_front, area) ||
                        exceeds(green_tally[2], cfg_side, area);
      rep.green_in_front = (exceeds(green_tally[1], cfg_center, area) &&
                            green_tally[1] > green_tally[0] &&
                            green_tally[1] > green_tally[2]) ||
                           (exceeds(green_tally[1], AHEAD_SHARE, area) && dark_any);
      rep.yellow_line = exceeds(yellow_tally[0], YSIDE_SHARE, area) &&
                        exceeds(yellow_tally[1], YCTR_SHARE, area) &&
                        exceeds(yellow_tally[2], YSIDE_SHARE, area);
      rep.left_green_count   = green_tally[0];
      rep.center_green_count = green_tally[1];
      rep.right_green_count  = green_tally[2];
      frame_reports_q.push_back(rep);
      green_tally  = '{default: '0};
      yellow_tally = '{default: '0};
      dark_tally   = '{default: '0};
      col_pos = 0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // idle-free stretches for both sides
  always @(posedge clk_i) begin
    if (calm_timer == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_timer <= $urandom_range(20, 120);
    end else begin
      calm_timer <= calm_timer - 1;
    end
  end

  // pixel driver
  always @(posedge clk_i) begin : pixel_driver
    int gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      tally_pixel(in_pixel_i);
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap == 0 && pixel_q.size() != 0) begin
        in_pixel_i <= pixel_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        in_gap <= gap;
      end
    end else if (!in_valid_i) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
      end else if (pixel_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_pixel_i <= pixel_q.pop_front();
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    int      n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (frame_reports_q.size() == 0) begin
        $error("result beat with no frame pending");
        fail_cnt++;
      end else begin
        want = frame_reports_q.pop_front();
        check_field("green_close", want.green_close, out_result_o.green_close);
        check_field("green_in_front", want.green_in_front, out_result_o.green_in_front);
        check_field("yellow_line", want.yellow_line, out_result_o.yellow_line);
        check_field("left_green_count", want.left_green_count,
                    out_result_o.left_green_count);
        check_field("center_green_count", want.center_green_count,
                    out_result_o.center_green_count);
        check_field("right_green_count", want.right_green_count,
                    out_result_o.right_green_count);
      end
      n = calm ? 0 : $urandom_range(0, 3);
      hold_left <= n;
      out_stall_i <= (n != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= (hold_left > 1);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    while (pixel_q.size() != 0 || in_valid_i || frame_reports_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [10:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_FRAME_WIDTH:      cfg_width = val;
      CFG_FRAME_HEIGHT:     cfg_height = val;
      CFG_DARK_LEVEL:       cfg_dark = val[7:0];
      CFG_GREEN_SIDE_PCT:   cfg_side = val[6:0];
      CFG_GREEN_FRONT_PCT:  cfg_front = val[6:0];
      CFG_GREEN_CENTER_PCT: cfg_center = val[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [10:0] w, input logic [10:0] h,
                           input logic [10:0] dark, input logic [10:0] side,
                           input logic [10:0] front, input logic [10:0] center);
    drain();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_DARK_LEVEL, dark);
    write_reg(CFG_GREEN_SIDE_PCT, side);
    write_reg(CFG_GREEN_FRONT_PCT, front);
    write_reg(CFG_GREEN_CENTER_PCT, center);
    cfg_we_i <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send(input int r, input int g, input int b, input logic last);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.frame_last = last;
    pixel_q.push_back(px);
  endtask

  function automatic pixel_t make_pixel(input pixel_kind_e kind, input logic last);
    pixel_t px;
    int     g, r, lim;
    px.red = $urandom_range(0, 255);
    px.green = $urandom_range(0, 255);
    px.blue = $urandom_range(0, 255);
    px.frame_last = last;
    case (kind)
      KIND_GREEN: begin
        g = $urandom_range(G_FLOOR, 255);
        lim = g - g / 2 + 1;
        px.green = g;
        px.red = $urandom_range(0, lim);
        px.blue = $urandom_range(0, lim);
      end
      KIND_YELLOW: begin
        r = $urandom_range(Y_FLOOR, 255);
        g = $urandom_range(Y_FLOOR, 255);
        lim = ((r < g) ? r : g) - Y_BLUE_GAP + 1;
        px.red = r;
        px.green = g;
        px.blue = $urandom_range(0, lim);
      end
      KIND_DARK: begin
        if (cfg_dark != 0) begin
          px.red = $urandom_range(0, cfg_dark);
          px.green = $urandom_range(0, cfg_dark - 1);
          px.blue = $urandom_range(0, cfg_dark - 1);
        end
      end
      default: ;
    endcase
    return px;
  endfunction

  // pixels with per-third class mix, following the expected column
  task automatic queue_frame(input int len, input logic ends);
    int          pg [3], py [3];
    int          pd, roll, weff, p, i;
    pixel_kind_e kind;
    weff = eff_width(cfg_width);
    for (p = 0; p < 3; p++) begin
      pg[p] = SHARES[$urandom_range(0, 3)];
      py[p] = SHARES[$urandom_range(0, 3)];
    end
    pd = SHARES[$urandom_range(0, 3)];
    for (i = 0; i < len; i++) begin
      if (plan_col < weff / 3) p = 0;
      else if (plan_col < (2 * weff) / 3) p = 1;
      else p = 2;
      roll = $urandom_range(0, 99);
      if (roll < pg[p]) kind = KIND_GREEN;
      else if (roll < pg[p] + py[p]) kind = KIND_YELLOW;
      else if (roll < pg[p] + py[p] + pd) kind = KIND_DARK;
      else kind = KIND_NOISE;
      pixel_q.push_back(make_pixel(kind, ends && (i == len - 1)));
      plan_col = (plan_col + 1 >= weff) ? 0 : plan_col + 1;
    end
    if (ends) plan_col = 0;
  endtask

  initial begin : stimulus
    logic [10:0] w, h, dark, pct [3];
    int          ph, k, queued, weff, len;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    send(0, 50, 0, 1'b0);
    send(255, 255, 255, 1'b0);
    send(0, 0, 0, 1'b1);

    // one pixel per third, zero thresholds
    configure(3, 1, 255, 0, 0, 0);
    send(0, 255, 0, 1'b0);
    send(255, 255, 0, 1'b0);
    send(0, 0, 0, 1'b1);
    send(25, 50, 25, 1'b0);
    send(150, 150, 100, 1'b0);
    send(254, 254, 254, 1'b1);
    send(26, 50, 25, 1'b0);
    send(149, 150, 100, 1'b0);
    send(255, 0, 0, 1'b1);
    send(0, 49, 0, 1'b0);
    send(200, 255, 205, 1'b0);
    send(255, 255, 255, 1'b1);

    // oversized width and height, top thresholds
    configure(2047, 2047, 0, 127, 127, 127);
    send(0, 255, 0, 1'b0);
    send(255, 255, 255, 1'b0);
    send(0, 0, 0, 1'b1);

    // zero width and height, row wrap inside one frame
    configure(0, 0, 255, 100, 100, 100);
    send(0, 200, 0, 1'b0);
    send(0, 200, 0, 1'b0);
    send(10, 10, 10, 1'b0);
    send(0, 200, 0, 1'b1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
        2:       w = $urandom_range(3, 2047);
        default: w = $urandom_range(3, 24);
      endcase
      case ($urandom_range(0, 7))
        0:       h = 0;
        1:       h = 2047;
        2:       h = $urandom_range(1, 1024);
        default: h = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 4))
        0:       dark = 0;
        1:       dark = 255 | ($urandom_range(0, 7) << 8);
        default: dark = $urandom_range(0, 255);
      endcase
      for (k = 0; k < 3; k++) begin
        case ($urandom_range(0, 5))
          0:       pct[k] = 0;
          1:       pct[k] = 127 | ($urandom_range(0, 15) << 7);
          2:       pct[k] = $urandom_range(0, 127) | ($urandom_range(0, 15) << 7);
          default: pct[k] = $urandom_range(0, 40);
        endcase
      end
      configure(w, h, dark, pct[0], pct[1], pct[2]);

      weff = eff_width(cfg_width);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if (weff <= 48) begin
          case ($urandom_range(0, 5))
            0:       len = 1;
            1:       len = $urandom_range(1, 3 * weff);
            default: len = weff * $urandom_range(1, 3);
          endcase
        end else begin
          len = ($urandom_range(0, 7) == 0) ? weff : $urandom_range(1, 60);
        end
        queue_frame(len, 1'b1);
        queued += len;
      end
      // unfinished frame carried into the next setting
      if ($urandom_range(0, 1))
        queue_frame($urandom_range(1, (weff > 48) ? 40 : weff), 1'b0);
    end

    drain();
    if (fail_cnt == 0 && frame_reports_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/crpd_pkg.sv
hw/rtl/crpd_front.sv
hw/rtl/crpd_queue.sv
hw/rtl/crpd_back.sv
hw/rtl/color_region_pixel_detector_core.sv
bench/tb_color_region_pixel_detector_core.sv
